/* hdl/its_pkg.sv */
// Shared types and constants for the ISO 8601 timestamp to epoch converter.
// Used by the parser front end, the job queue and the epoch arithmetic back end.
`timescale 1ns / 1ps

package its_pkg;

    // One parsed timestamp, handed from the parser to the arithmetic unit.
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [9:0]  millis;
    } job_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int EPOCH_W     = 49;
    localparam int TDATA_W     = 56;

    // Reciprocal constants for the divisions by 400, by 100 and by 5.
    localparam logic [12:0] RECIP_400 = 13'd5243;   // 2^21 / 400, rounded up
    localparam logic [15:0] RECIP_5   = 16'd52429;  // 2^18 / 5, rounded up
    localparam logic [5:0]  RECIP_100 = 6'd41;      // 2^12 / 100, rounded up

    localparam logic signed [23:0] DAYS_PER_ERA = 24'sd146097;
    localparam logic signed [23:0] EPOCH_SHIFT  = 24'sd719468;
    localparam logic signed [51:0] MS_PER_DAY   = 52'sd86400000;

endpackage

/* hdl/iso_timestamp_to_epoch_ms.sv */
// ISO 8601 UTC timestamp (YYYY-MM-DDTHH:MM:SS[.fff...]Z) to Unix epoch milliseconds.
// The parser takes one character per cycle; each string's last beat queues one job
// (two-entry queue), and the arithmetic sequencer takes each job from idle through
// ERA, YOE, DOE, DAYS, SCALE and OUT, waiting in OUT while the output register is
// full, then loads it. Long strings therefore run at one character per cycle;
// strings shorter than the sequencer's state count are limited by it, and the
// input stalls while the queue is full. Every string yields exactly one output beat.
`timescale 1ns / 1ps

module iso_timestamp_to_epoch_ms
    import its_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] text_char
    input  logic               s_axis_tlast,   // end_of_text
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [48:0] epoch_millis, rest zero
    output logic               m_axis_tuser    // [0] parse_ok
);

    logic               char_accept;
    logic               job_push;
    job_t               front_job;
    job_t               queue_job;
    logic               job_pop;
    logic               queue_full;
    logic               queue_empty;
    logic [EPOCH_W-1:0] epoch;

    assign s_axis_tready = !queue_full;
    assign char_accept   = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = {{(TDATA_W - EPOCH_W){1'b0}}, epoch};

    its_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_accept (char_accept),
        .text_char   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .job_push    (job_push),
        .job         (front_job)
    );

    its_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (front_job),
        .pop      (job_pop),
        .pop_job  (queue_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    its_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (queue_empty),
        .job_in    (queue_job),
        .job_pop   (job_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_ok    (m_axis_tuser),
        .out_epoch (epoch)
    );

endmodule

/* hdl/its_front.sv */
// Character parser: checks the timestamp format and builds the decimal fields.
// Depends on its_pkg; hands one job per string to the queue.
`timescale 1ns / 1ps

module its_front
    import its_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_accept,
    input  logic [7:0] text_char,
    input  logic       end_of_text,
    output logic       job_push,
    output job_t       job
);

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [4:0] POS_SUFFIX = 5'd19;
    localparam logic [4:0] POS_FRAC   = 5'd20;

    logic [4:0]  pos_reg, pos_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [9:0]  millis_reg, millis_next;
    logic [1:0]  frac_cnt_reg, frac_cnt_next;
    logic        bad_reg, bad_next;

    logic        digit;
    logic [3:0]  dval;
    logic [7:0]  dsub;
    logic [9:0]  weight;
    logic        is_z;

    always_comb
    begin
        digit  = text_char inside {[8'h30:8'h39]};
        dsub   = text_char - CHAR_ZERO;
        dval   = digit ? dsub[3:0] : 4'd0;
        is_z   = (text_char == CHAR_Z);
        case (frac_cnt_reg)
            2'd0:    weight = 10'd100;
            2'd1:    weight = 10'd10;
            default: weight = 10'd1;
        endcase

        pos_next      = pos_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        millis_next   = millis_reg;
        frac_cnt_next = frac_cnt_reg;
        bad_next      = bad_reg;

        if (pos_reg < POS_SUFFIX)
        begin
            if (pos_reg == 5'd4 || pos_reg == 5'd7)
            begin
                if (text_char != CHAR_DASH) bad_next = 1'b1;
            end
            else if (pos_reg == 5'd10)
            begin
                if (text_char != CHAR_T) bad_next = 1'b1;
            end
            else if (pos_reg == 5'd13 || pos_reg == 5'd16)
            begin
                if (text_char != CHAR_COLON) bad_next = 1'b1;
            end
            else if (!digit)
                bad_next = 1'b1;
            else if (pos_reg < 5'd4)
                year_next = 14'(year_reg * 14'd10 + {10'd0, dval});
            else if (pos_reg < 5'd7)
                month_next = 7'(month_reg * 7'd10 + {3'd0, dval});
            else if (pos_reg < 5'd10)
                day_next = 7'(day_reg * 7'd10 + {3'd0, dval});
            else if (pos_reg < 5'd13)
                hour_next = 7'(hour_reg * 7'd10 + {3'd0, dval});
            else if (pos_reg < 5'd16)
                minute_next = 7'(minute_reg * 7'd10 + {3'd0, dval});
            else
                second_next = 7'(second_reg * 7'd10 + {3'd0, dval});
        end
        else if (pos_reg == POS_SUFFIX)
        begin
            if (is_z)
            begin
                if (!end_of_text) bad_next = 1'b1;
            end
            else if (text_char != CHAR_DOT)
                bad_next = 1'b1;
        end
        else
        begin
            if (digit)
            begin
                // Digits past the third are checked but carry no weight.
                if (frac_cnt_reg != 2'd3)
                begin
                    millis_next   = 10'(millis_reg + weight * {6'd0, dval});
                    frac_cnt_next = frac_cnt_reg + 2'd1;
                end
            end
            else if (is_z)
            begin
                if (!end_of_text) bad_next = 1'b1;
            end
            else
                bad_next = 1'b1;
        end

        if (pos_reg < POS_FRAC) pos_next = pos_reg + 5'd1;
    end

    // The closing 'Z' never changes a field, so the stored fields are final.
    always_comb
    begin
        job_push   = char_accept && end_of_text;
        job.ok     = !bad_reg && (pos_reg >= POS_SUFFIX) && is_z;
        job.year   = year_reg;
        job.month  = month_reg;
        job.day    = day_reg;
        job.hour   = hour_reg;
        job.minute = minute_reg;
        job.second = second_reg;
        job.millis = millis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            year_reg     <= '0;
            month_reg    <= '0;
            day_reg      <= '0;
            hour_reg     <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
            millis_reg   <= '0;
            frac_cnt_reg <= '0;
            bad_reg      <= 1'b0;
        end
        else if (char_accept)
        begin
            if (end_of_text)
            begin
                pos_reg      <= '0;
                year_reg     <= '0;
                month_reg    <= '0;
                day_reg      <= '0;
                hour_reg     <= '0;
                minute_reg   <= '0;
                second_reg   <= '0;
                millis_reg   <= '0;
                frac_cnt_reg <= '0;
                bad_reg      <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                year_reg     <= year_next;
                month_reg    <= month_next;
                day_reg      <= day_next;
                hour_reg     <= hour_next;
                minute_reg   <= minute_next;
                second_reg   <= second_next;
                millis_reg   <= millis_next;
                frac_cnt_reg <= frac_cnt_next;
                bad_reg      <= bad_next;
            end
        end
    end

endmodule

/* hdl/its_queue.sv */
// Two-entry job queue between the parser and the epoch arithmetic.
// Depends on its_pkg for the job type and depth.
`timescale 1ns / 1ps

module its_queue
    import its_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full) entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if ((push && !full) && !(pop && !empty))
                count_reg <= count_reg + 1'b1;
            else if (!(push && !full) && (pop && !empty))
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* hdl/its_back.sv */
// Epoch arithmetic: days-from-civil and the scale to milliseconds. Depends on its_pkg;
// takes queue jobs and loads the output register, one step per cycle while it is free.
`timescale 1ns / 1ps

module its_back
    import its_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_empty,
    input  job_t                 job_in,
    output logic                 job_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_ok,
    output logic [EPOCH_W-1:0]   out_epoch
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERA,
        ST_YOE,
        ST_DOE,
        ST_DAYS,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic [EPOCH_W-1:0]   out_epoch_reg;

    job_t                 job_reg;
    logic                 neg_reg;
    logic [13:0]          ypos_reg;
    logic [5:0]           era_q_reg;
    logic [14:0]          mp153_reg;
    logic [18:0]          hms_reg;
    logic [8:0]           yoe_reg;
    logic [12:0]          doy_reg;
    logic [28:0]          tod_reg;
    logic [18:0]          doe_reg;
    logic signed [23:0]   era_days_reg;
    logic signed [23:0]   days_reg;
    logic signed [51:0]   days_ms_reg;

    logic                 early_month;
    logic [13:0]          ypos_next;
    logic                 neg_next;
    logic [26:0]          era_prod;
    logic [6:0]           mp;
    logic [14:0]          mp153_next;
    logic [18:0]          hms_next;
    logic [8:0]           yoe_next;
    logic [30:0]          doy_prod;
    logic [12:0]          doy_next;
    logic [28:0]          tod_next;
    logic [17:0]          yoe365;
    logic [13:0]          yoe41;
    logic [18:0]          doe_next;
    logic signed [23:0]   era_ext;
    logic signed [23:0]   era_days_next;
    logic signed [23:0]   doe_ext;
    logic signed [23:0]   days_next;
    logic signed [51:0]   days_ext;
    logic signed [51:0]   days_ms_next;
    logic [51:0]          total;
    logic                 out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign job_pop   = (state_reg == ST_IDLE) && !job_empty;
    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_epoch = out_epoch_reg;

    always_comb
    begin
        // Year, era and month shift; also the time of day in seconds.
        early_month = (job_reg.month <= 7'd2);
        ypos_next   = job_reg.year - {13'd0, early_month};
        neg_next    = (job_reg.year == 14'd0) && early_month;
        era_prod    = {13'd0, ypos_next} * {14'd0, RECIP_400};
        mp          = early_month ? 7'(job_reg.month + 7'd9) : 7'(job_reg.month - 7'd3);
        mp153_next  = 15'({8'd0, mp} * 15'd153 + 15'd2);
        hms_next    = 19'({12'd0, job_reg.hour} * 19'd3600 + {12'd0, job_reg.minute} * 19'd60
                          + {12'd0, job_reg.second});

        // Year of era, day of year, time of day in milliseconds.
        yoe_next    = neg_reg ? 9'd399 : 9'(ypos_reg - 14'({8'd0, era_q_reg} * 14'd400));
        doy_prod    = {16'd0, mp153_reg} * {15'd0, RECIP_5};
        doy_next    = 13'(doy_prod[30:18] + {6'd0, job_reg.day} - 13'd1);
        tod_next    = 29'({10'd0, hms_reg} * 29'd1000 + {19'd0, job_reg.millis});

        // Day of era and the era's day offset.
        yoe365      = 18'({9'd0, yoe_reg} * 18'd365);
        yoe41       = 14'({5'd0, yoe_reg} * {8'd0, RECIP_100});
        doe_next    = 19'({1'b0, yoe365} + {12'd0, yoe_reg[8:2]} - {17'd0, yoe41[13:12]}
                          + {{6{doy_reg[12]}}, doy_reg});
        era_ext     = neg_reg ? -24'sd1 : $signed({18'd0, era_q_reg});
        era_days_next = era_ext * DAYS_PER_ERA;

        doe_ext     = $signed({{5{doe_reg[18]}}, doe_reg});
        days_next   = era_days_reg + doe_ext - EPOCH_SHIFT;

        days_ext    = $signed({{28{days_reg[23]}}, days_reg});
        days_ms_next = days_ext * MS_PER_DAY;

        total       = days_ms_reg + $signed({23'd0, tod_reg});
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty) job_reg <= job_in;
            end
            ST_ERA:
            begin
                ypos_reg  <= ypos_next;
                neg_reg   <= neg_next;
                era_q_reg <= era_prod[26:21];
                mp153_reg <= mp153_next;
                hms_reg   <= hms_next;
            end
            ST_YOE:
            begin
                yoe_reg <= yoe_next;
                doy_reg <= doy_next;
                tod_reg <= tod_next;
            end
            ST_DOE:
            begin
                doe_reg      <= doe_next;
                era_days_reg <= era_days_next;
            end
            ST_DAYS:
            begin
                days_reg <= days_next;
            end
            ST_SCALE:
            begin
                days_ms_reg <= days_ms_next;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_epoch_reg <= '0;
        end
        else
        begin
            out_valid_reg <= (state_reg == ST_OUT && out_free) || (out_valid_reg && !out_ready);
            case (state_reg)
                ST_IDLE:  if (!job_empty) state_reg <= ST_ERA;
                ST_ERA:   state_reg <= ST_YOE;
                ST_YOE:   state_reg <= ST_DOE;
                ST_DOE:   state_reg <= ST_DAYS;
                ST_DAYS:  state_reg <= ST_SCALE;
                ST_SCALE: state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_ok_reg    <= job_reg.ok;
                        out_epoch_reg <= job_reg.ok ? total[EPOCH_W-1:0] : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ok_reg |-> out_epoch_reg == '0)
        else $error("failed parse carries a nonzero epoch");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> state_reg == ST_ERA)
        else $error("job taken but sequencer did not start");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished job not placed in output register");
`endif

endmodule
